### hw/rtl/cfbs_pkg.sv
`default_nettype none

package cfbs_pkg;

	localparam int unsigned ID_W          = 11;
	localparam int unsigned DLC_W         = 4;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned CKSUM_W       = 15;
	localparam int unsigned RUN_W         = 3;
	localparam int unsigned REM_W         = 4;

	// stuffed region: SOF, ID, RTR, IDE, r0, DLC, then checksum on the closing item
	localparam int unsigned HDR_BITS      = 1 + ID_W + 3 + DLC_W;
	localparam int unsigned FIELD_W       = HDR_BITS + CKSUM_W;
	localparam int unsigned NBITS_W       = $clog2(FIELD_W + 1);

	localparam int unsigned INTERFRAME_BITS = 3;
	localparam int unsigned EOF_BITS        = 7;
	localparam int unsigned TAIL_BITS       = 3 + EOF_BITS;
	localparam int unsigned PRE_W           = $clog2(INTERFRAME_BITS + 1);
	localparam int unsigned POST_W          = $clog2(TAIL_BITS + 1);

	localparam int unsigned RESULT_LIMIT  = 56;
	localparam int unsigned EMIT_W        = $clog2(RESULT_LIMIT);

	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_DATA   = 1'b1;

	typedef struct packed {
		logic               header;
		logic               finish;
		logic [FIELD_W-1:0] bits;
		logic [NBITS_W-1:0] nbits;
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PRE,
		BK_DATA,
		BK_STUFF,
		BK_POST
	} bk_state_t;

endpackage

`default_nettype wire

### hw/rtl/cfbs_front.sv
`default_nettype none

module cfbs_front #(
	parameter int unsigned MAX_DATA_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         operation,
	input  wire logic [cfbs_pkg::ID_W-1:0]    identifier,
	input  wire logic [cfbs_pkg::DLC_W-1:0]   length_code,
	input  wire logic [cfbs_pkg::BYTE_W-1:0]  payload_byte,
	output logic                              cmd_valid,
	input  wire logic                         cmd_ready,
	output cfbs_pkg::cmd_t                    cmd
);

	logic                           frame_open_q;
	logic [cfbs_pkg::REM_W-1:0]     bytes_rem_q;
	logic [cfbs_pkg::CKSUM_W-1:0]   cksum_q;

	logic                           accept;
	logic [cfbs_pkg::REM_W-1:0]     hdr_rem;
	logic [cfbs_pkg::REM_W-1:0]     data_rem;
	logic [cfbs_pkg::CKSUM_W-1:0]   cksum_sum;
	logic                           stray;

	assign in_ready = cmd_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		hdr_rem   = (length_code > cfbs_pkg::DLC_W'(MAX_DATA_BYTES))
			? cfbs_pkg::REM_W'(MAX_DATA_BYTES) : length_code;
		data_rem  = bytes_rem_q - cfbs_pkg::REM_W'(1);
		cksum_sum = cksum_q + cfbs_pkg::CKSUM_W'(payload_byte);
		stray     = !frame_open_q || (bytes_rem_q == '0);
	end

	// classify the item and build the bit field the back end will stuff
	always_comb begin
		cmd = '0;
		if (operation == cfbs_pkg::OP_HEADER) begin
			cmd.header = 1'b1;
			cmd.finish = (hdr_rem == '0);
			cmd.bits   = {1'b0, identifier, 1'b1, 1'b0, 1'b0, length_code,
				{cfbs_pkg::CKSUM_W{1'b0}}};
			cmd.nbits  = cmd.finish ? cfbs_pkg::NBITS_W'(cfbs_pkg::FIELD_W)
				: cfbs_pkg::NBITS_W'(cfbs_pkg::HDR_BITS);
		end else begin
			cmd.header = 1'b0;
			cmd.finish = (data_rem == '0);
			cmd.bits   = {payload_byte, cksum_sum,
				{(cfbs_pkg::FIELD_W - cfbs_pkg::BYTE_W - cfbs_pkg::CKSUM_W){1'b0}}};
			cmd.nbits  = cmd.finish
				? cfbs_pkg::NBITS_W'(cfbs_pkg::BYTE_W + cfbs_pkg::CKSUM_W)
				: cfbs_pkg::NBITS_W'(cfbs_pkg::BYTE_W);
		end
	end

	// stray data bytes are swallowed here
	assign cmd_valid = in_valid && ((operation == cfbs_pkg::OP_HEADER) || !stray);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			bytes_rem_q  <= '0;
			cksum_q      <= '0;
		end else if (accept) begin
			if (operation == cfbs_pkg::OP_HEADER) begin
				cksum_q      <= '0;
				bytes_rem_q  <= hdr_rem;
				frame_open_q <= (hdr_rem != '0);
			end else if (!stray) begin
				cksum_q      <= cksum_sum;
				bytes_rem_q  <= data_rem;
				frame_open_q <= (data_rem != '0);
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cfbs_queue.sv
`default_nettype none

module cfbs_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	input  wire cfbs_pkg::cmd_t wr_data,
	output logic                rd_valid,
	input  wire logic           rd_ready,
	output cfbs_pkg::cmd_t      rd_data
);

	cfbs_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           push;
	logic           pop;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/cfbs_back.sv
`default_nettype none

module cfbs_back #(
	parameter int unsigned STUFF_RUN = 5
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire cfbs_pkg::cmd_t cmd,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic                bus_level,
	output logic                stuff_bit,
	output logic                last_bit
);

	cfbs_pkg::bk_state_t            state_q;
	cfbs_pkg::bk_state_t            state_d;

	logic [cfbs_pkg::FIELD_W-1:0]   bits_q;
	logic [cfbs_pkg::NBITS_W-1:0]   bit_cnt_q;
	logic [cfbs_pkg::PRE_W-1:0]     pre_cnt_q;
	logic [cfbs_pkg::POST_W-1:0]    post_cnt_q;
	logic [cfbs_pkg::EMIT_W-1:0]    emit_cnt_q;
	logic                           run_level_q;
	logic [cfbs_pkg::RUN_W-1:0]     run_len_q;
	logic                           out_valid_q;
	logic                           bus_level_q;
	logic                           stuff_bit_q;
	logic                           last_bit_q;

	logic                           adv;
	logic                           load;
	logic                           lvl_data;
	logic [cfbs_pkg::RUN_W-1:0]     run_next;
	logic                           stuff_now;
	logic                           emit_level;
	logic                           limit_hit;
	cfbs_pkg::bk_state_t            tail_state;

	assign adv       = (state_q != cfbs_pkg::BK_IDLE) && (!out_valid_q || out_ready);
	assign load      = (state_q == cfbs_pkg::BK_IDLE) && cmd_valid;
	assign cmd_ready = (state_q == cfbs_pkg::BK_IDLE);

	// bit values and stuffing decision for the current cycle
	always_comb begin
		lvl_data   = bits_q[cfbs_pkg::FIELD_W-1];
		run_next   = ((run_len_q != '0) && (lvl_data == run_level_q))
			? run_len_q + cfbs_pkg::RUN_W'(1) : cfbs_pkg::RUN_W'(1);
		stuff_now  = (run_next >= cfbs_pkg::RUN_W'(STUFF_RUN));
		limit_hit  = (emit_cnt_q == cfbs_pkg::EMIT_W'(cfbs_pkg::RESULT_LIMIT - 1));
		tail_state = (post_cnt_q != '0) ? cfbs_pkg::BK_POST : cfbs_pkg::BK_IDLE;
		case (state_q)
			cfbs_pkg::BK_DATA:  emit_level = lvl_data;
			cfbs_pkg::BK_STUFF: emit_level = run_level_q;
			default:            emit_level = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cfbs_pkg::BK_IDLE: begin
				if (cmd_valid) begin
					state_d = cmd.header ? cfbs_pkg::BK_PRE : cfbs_pkg::BK_DATA;
				end
			end
			cfbs_pkg::BK_PRE: begin
				if (adv && (pre_cnt_q == cfbs_pkg::PRE_W'(1))) begin
					state_d = cfbs_pkg::BK_DATA;
				end
			end
			cfbs_pkg::BK_DATA: begin
				if (adv) begin
					if (stuff_now) begin
						state_d = cfbs_pkg::BK_STUFF;
					end else if (bit_cnt_q > cfbs_pkg::NBITS_W'(1)) begin
						state_d = cfbs_pkg::BK_DATA;
					end else begin
						state_d = tail_state;
					end
				end
			end
			cfbs_pkg::BK_STUFF: begin
				if (adv) begin
					state_d = (bit_cnt_q != '0) ? cfbs_pkg::BK_DATA : tail_state;
				end
			end
			cfbs_pkg::BK_POST: begin
				if (adv && (post_cnt_q == cfbs_pkg::POST_W'(1))) begin
					state_d = cfbs_pkg::BK_IDLE;
				end
			end
			default: state_d = cfbs_pkg::BK_IDLE;
		endcase
		// result cap per item: anything beyond is dropped
		if (adv && limit_hit) begin
			state_d = cfbs_pkg::BK_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cfbs_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
			bit_cnt_q   <= '0;
			pre_cnt_q   <= '0;
			post_cnt_q  <= '0;
			emit_cnt_q  <= '0;
			run_level_q <= 1'b1;
			run_len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				bit_cnt_q  <= cmd.nbits;
				pre_cnt_q  <= cfbs_pkg::PRE_W'(cfbs_pkg::INTERFRAME_BITS);
				post_cnt_q <= cmd.finish ? cfbs_pkg::POST_W'(cfbs_pkg::TAIL_BITS) : '0;
				emit_cnt_q <= '0;
				if (cmd.header) begin
					run_level_q <= 1'b1;
					run_len_q   <= '0;
				end
			end else if (adv) begin
				emit_cnt_q <= emit_cnt_q + cfbs_pkg::EMIT_W'(1);
				case (state_q)
					cfbs_pkg::BK_PRE: pre_cnt_q <= pre_cnt_q - cfbs_pkg::PRE_W'(1);
					cfbs_pkg::BK_DATA: begin
						bit_cnt_q   <= bit_cnt_q - cfbs_pkg::NBITS_W'(1);
						run_level_q <= stuff_now ? ~lvl_data : lvl_data;
						run_len_q   <= stuff_now ? cfbs_pkg::RUN_W'(1) : run_next;
					end
					cfbs_pkg::BK_POST: post_cnt_q <= post_cnt_q - cfbs_pkg::POST_W'(1);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bits_q <= cmd.bits;
		end else if (adv && (state_q == cfbs_pkg::BK_DATA)) begin
			bits_q <= {bits_q[cfbs_pkg::FIELD_W-2:0], 1'b0};
		end
		if (adv) begin
			bus_level_q <= emit_level;
			stuff_bit_q <= (state_q == cfbs_pkg::BK_STUFF);
			last_bit_q  <= (state_d == cfbs_pkg::BK_IDLE);
		end
	end

	assign out_valid = out_valid_q;
	assign bus_level = bus_level_q;
	assign stuff_bit = stuff_bit_q;
	assign last_bit  = last_bit_q;

endmodule

`default_nettype wire

### hw/rtl/can_frame_bit_serializer_top.sv
// channel  handshake             payload
// in       in_valid / in_ready   operation, identifier, length_code, payload_byte
// out      out_valid / out_ready bus_level, stuff_bit, last_bit
//
// One bus bit leaves per cycle while out_ready does not stall it, once an item
// reaches the serializer, which loads each item from the two-entry command queue.
// The bits an item produces depend on field length, stuff bits and the closing
// checksum and tail, with a hard cap of 56 bits.
// Reset clears frame tracking, run state and the queue; no clearing pass.
// Output stalls hold the serializer; the queue lets the front keep accepting.

`default_nettype none

module can_frame_bit_serializer_top #(
	parameter int unsigned MAX_DATA_BYTES = 8,
	parameter int unsigned STUFF_RUN      = 5
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         operation,
	input  wire logic [cfbs_pkg::ID_W-1:0]    identifier,
	input  wire logic [cfbs_pkg::DLC_W-1:0]   length_code,
	input  wire logic [cfbs_pkg::BYTE_W-1:0]  payload_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              bus_level,
	output logic                              stuff_bit,
	output logic                              last_bit
);

	logic           fq_valid;
	logic           fq_ready;
	cfbs_pkg::cmd_t fq_cmd;
	logic           qb_valid;
	logic           qb_ready;
	cfbs_pkg::cmd_t qb_cmd;

	cfbs_front #(
		.MAX_DATA_BYTES(MAX_DATA_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.identifier   (identifier),
		.length_code  (length_code),
		.payload_byte (payload_byte),
		.cmd_valid    (fq_valid),
		.cmd_ready    (fq_ready),
		.cmd          (fq_cmd)
	);

	cfbs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_cmd),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_data  (qb_cmd)
	);

	cfbs_back #(
		.STUFF_RUN(STUFF_RUN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (qb_valid),
		.cmd_ready (qb_ready),
		.cmd       (qb_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bus_level (bus_level),
		.stuff_bit (stuff_bit),
		.last_bit  (last_bit)
	);

endmodule

`default_nettype wire

### dv/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_BYTES  = 8;
	localparam int unsigned RUN_LIMIT  = 5;
	localparam int unsigned DRAIN_CYC  = 80;

	typedef struct packed {
		logic level;
		logic stuffed;
		logic last;
	} bus_bit_t;

	// Bit-level predictor of the frame serializer plus the queue of bus bits
	// still owed by the block.
	class can_bit_scoreboard;
		int unsigned stuff_run;
		int unsigned max_bytes;
		bit          run_lvl;
		int unsigned run_len;
		bit [cfbs_pkg::CKSUM_W-1:0] checksum;
		int unsigned bytes_left;
		bit          frame_open;
		bus_bit_t    item_bits[$];
		bus_bit_t    pending_bits[$];
		int unsigned errors;
		int unsigned bits_checked;
		int unsigned headers;
		int unsigned data_bytes;
		int unsigned strays;

		function new(int unsigned run_limit, int unsigned byte_limit);
			stuff_run  = run_limit;
			max_bytes  = byte_limit;
			run_lvl    = 1'b1;
			run_len    = 0;
			checksum   = '0;
			bytes_left = 0;
			frame_open = 1'b0;
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("%0t ns: mismatch: %s", $time, what);
		endtask

		function void emit_raw(logic level, logic stuffed);
			bus_bit_t b;
			b.level   = level;
			b.stuffed = stuffed;
			b.last    = 1'b0;
			// bits past the per-item result limit are dropped
			if (item_bits.size() < cfbs_pkg::RESULT_LIMIT)
				item_bits.push_back(b);
		endfunction

		function void emit_stuffed(logic level);
			if (run_len > 0 && level == run_lvl) begin
				run_len++;
			end else begin
				run_lvl = level;
				run_len = 1;
			end
			emit_raw(level, 1'b0);
			if (run_len >= stuff_run) begin
				run_lvl = ~level;
				run_len = 1;
				emit_raw(run_lvl, 1'b1);
			end
		endfunction

		function void emit_field(logic [cfbs_pkg::CKSUM_W-1:0] value, int width);
			for (int i = width - 1; i >= 0; i--)
				emit_stuffed(value[i]);
		endfunction

		function void close_frame();
			emit_field(checksum, cfbs_pkg::CKSUM_W);
			// CRC delimiter, ACK slot, ACK delimiter, then EOF
			repeat (cfbs_pkg::TAIL_BITS) emit_raw(1'b1, 1'b0);
			frame_open = 1'b0;
			bytes_left = 0;
		endfunction

		// Returns how many bus bits the accepted item is expected to produce.
		function int note_item(logic op, logic [cfbs_pkg::ID_W-1:0] id,
				logic [cfbs_pkg::DLC_W-1:0] dlc, logic [cfbs_pkg::BYTE_W-1:0] data);
			item_bits.delete();
			if (op == cfbs_pkg::OP_HEADER) begin
				headers++;
				repeat (cfbs_pkg::INTERFRAME_BITS) emit_raw(1'b1, 1'b0);
				run_lvl    = 1'b1;
				run_len    = 0;
				checksum   = '0;
				frame_open = 1'b1;
				bytes_left = (dlc > max_bytes) ? max_bytes : dlc;
				emit_stuffed(1'b0);
				emit_field(cfbs_pkg::CKSUM_W'(id), cfbs_pkg::ID_W);
				emit_stuffed(1'b1);
				emit_stuffed(1'b0);
				emit_stuffed(1'b0);
				emit_field(cfbs_pkg::CKSUM_W'(dlc), cfbs_pkg::DLC_W);
				if (bytes_left == 0)
					close_frame();
			end else begin
				if (!frame_open || bytes_left == 0) begin
					strays++;
					return 0;
				end
				data_bytes++;
				emit_field(cfbs_pkg::CKSUM_W'(data), cfbs_pkg::BYTE_W);
				checksum = checksum + cfbs_pkg::CKSUM_W'(data);
				bytes_left--;
				if (bytes_left == 0)
					close_frame();
			end
			item_bits[item_bits.size() - 1].last = 1'b1;
			foreach (item_bits[i])
				pending_bits.push_back(item_bits[i]);
			return item_bits.size();
		endfunction

		task check_bit(logic level, logic stuffed, logic last);
			bus_bit_t want;
			if (pending_bits.size() == 0) begin
				report_mismatch($sformatf("unexpected bit level=%b stuff=%b last=%b",
					level, stuffed, last));
			end else begin
				want = pending_bits.pop_front();
				bits_checked++;
				if (level !== want.level)
					report_mismatch($sformatf("bit %0d bus_level %b, want %b",
						bits_checked, level, want.level));
				if (stuffed !== want.stuffed)
					report_mismatch($sformatf("bit %0d stuff_bit %b, want %b",
						bits_checked, stuffed, want.stuffed));
				if (last !== want.last)
					report_mismatch($sformatf("bit %0d last_bit %b, want %b",
						bits_checked, last, want.last));
			end
		endtask
	endclass

	logic                              clk          = 1'b0;
	logic                              arst_n       = 1'b0;
	logic                              in_valid     = 1'b0;
	logic                              in_ready;
	logic                              operation    = cfbs_pkg::OP_HEADER;
	logic [cfbs_pkg::ID_W-1:0]         identifier   = '0;
	logic [cfbs_pkg::DLC_W-1:0]        length_code  = '0;
	logic [cfbs_pkg::BYTE_W-1:0]       payload_byte = '0;
	logic                              out_valid;
	logic                              out_ready    = 1'b0;
	logic                              bus_level;
	logic                              stuff_bit;
	logic                              last_bit;

	int unsigned in_idle_pct   = 0;
	int unsigned out_stall_pct = 0;
	int unsigned items_taken   = 0;

	can_bit_scoreboard sb = new(RUN_LIMIT, MAX_BYTES);

	can_frame_bit_serializer_top #(
		.MAX_DATA_BYTES(MAX_BYTES),
		.STUFF_RUN     (RUN_LIMIT)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.identifier  (identifier),
		.length_code (length_code),
		.payload_byte(payload_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.bus_level   (bus_level),
		.stuff_bit   (stuff_bit),
		.last_bit    (last_bit)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_bit(bus_level, stuff_bit, last_bit);
	end

	function automatic logic [cfbs_pkg::BYTE_W-1:0] pick_byte();
		case ($urandom_range(4))
			0: return 8'h00;
			1: return 8'hFF;
			default: return cfbs_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	task automatic send_item(logic op, logic [cfbs_pkg::ID_W-1:0] id,
			logic [cfbs_pkg::DLC_W-1:0] dlc, logic [cfbs_pkg::BYTE_W-1:0] data);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		identifier   <= id;
		length_code  <= dlc;
		payload_byte <= data;
		do @(posedge clk); while (!in_ready);
		if (sb.note_item(op, id, dlc, data) > 0)
			items_taken++;
	endtask

	// Well-formed frames with random content; now and then a stray byte or a
	// frame cut short by the next header.
	task automatic run_frames(int unsigned quota);
		int unsigned stop_at;
		int unsigned nbytes;
		int unsigned cut;
		logic [cfbs_pkg::ID_W-1:0]  id;
		logic [cfbs_pkg::DLC_W-1:0] dlc;
		stop_at = items_taken + quota;
		while (items_taken < stop_at) begin
			if ($urandom_range(99) < 8)
				send_item(cfbs_pkg::OP_DATA, cfbs_pkg::ID_W'($urandom),
					cfbs_pkg::DLC_W'($urandom), pick_byte());
			case ($urandom_range(5))
				0: id = '0;
				1: id = '1;
				default: id = cfbs_pkg::ID_W'($urandom);
			endcase
			dlc = ($urandom_range(99) < 70) ? cfbs_pkg::DLC_W'($urandom_range(8))
				: cfbs_pkg::DLC_W'($urandom_range(9, 15));
			nbytes = (dlc > MAX_BYTES) ? MAX_BYTES : dlc;
			cut = ($urandom_range(99) < 10) ? $urandom_range(nbytes) : nbytes;
			send_item(cfbs_pkg::OP_HEADER, id, dlc, cfbs_pkg::BYTE_W'($urandom));
			for (int k = 0; k < cut; k++)
				send_item(cfbs_pkg::OP_DATA, cfbs_pkg::ID_W'($urandom),
					cfbs_pkg::DLC_W'($urandom), pick_byte());
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: stray byte, extreme ids and codes, stuffing runs, abandoned frame
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'hA5);
		send_item(cfbs_pkg::OP_HEADER, 11'h000, 4'h0, 8'h00);
		send_item(cfbs_pkg::OP_HEADER, 11'h7FF, 4'hF, 8'hFF);
		send_item(cfbs_pkg::OP_DATA,   11'h7FF, 4'hF, 8'hFF);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'h00);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'hFF);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'h00);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'hAA);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'h55);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'h80);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'h01);
		send_item(cfbs_pkg::OP_DATA,   11'h555, 4'h5, 8'h3C);
		send_item(cfbs_pkg::OP_HEADER, 11'h555, 4'h3, 8'h00);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'h7C);
		send_item(cfbs_pkg::OP_HEADER, 11'h2AA, 4'h1, 8'h00);
		send_item(cfbs_pkg::OP_DATA,   11'h000, 4'h0, 8'hFF);
		send_item(cfbs_pkg::OP_HEADER, 11'h400, 4'h9, 8'h00);
		for (int k = 0; k < 8; k++)
			send_item(cfbs_pkg::OP_DATA, 11'h000, 4'h0, 8'hFF);

		in_idle_pct   = 26;
		out_stall_pct = 66;
		run_frames(107);
		in_idle_pct   = 66;
		out_stall_pct = 26;
		run_frames(107);
		in_idle_pct   = 0;
		out_stall_pct = 0;
		run_frames(106);
		in_valid <= 1'b0;

		while (sb.pending_bits.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("covered %0d headers, %0d data bytes and %0d stray bytes",
			sb.headers, sb.data_bytes, sb.strays);
		$display("%0d bus bits checked, %0d mismatches", sb.bits_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d bus bits outstanding", sb.pending_bits.size());
		$display("tb_top failed");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hw/rtl/cfbs_pkg.sv
hw/rtl/cfbs_front.sv
hw/rtl/cfbs_queue.sv
hw/rtl/cfbs_back.sv
hw/rtl/can_frame_bit_serializer_top.sv
dv/tb_top.sv
